// ===== rtl/core/lavm_pkg.sv =====
// shared types and constants for the look-at view matrix block
`timescale 1ns / 1ps

package lavm_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;

  // row numbers of the emitted matrix
  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_DIR   = 2'd2;
  localparam logic [1:0] ROW_LAST  = 2'd3;

  // one accepted item as the front hands it to the back
  typedef struct packed {
    logic [2:0][COORD_W-1:0] pos;
    logic [2:0][COORD_W-1:0] up;
    logic [2:0][DIFF_W-1:0]  dlt;
    logic                    dzero;
  } item_t;

  // one result row
  typedef struct packed {
    logic [1:0]         row_index;
    logic [COORD_W-1:0] col_a;
    logic [COORD_W-1:0] col_b;
    logic [COORD_W-1:0] col_c;
    logic [COORD_W-1:0] col_d;
    logic               degenerate;
    logic               last_row;
  } row_t;

  // normalize unit status
  typedef struct packed {
    logic done;
    logic ok;
  } nrm_stat_t;

endpackage

// ===== rtl/core/look_at_view_matrix_top.sv =====
// top level of the look-at view matrix block
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   pos, target, up (x, y, z), Q16.16
// out       output     out_valid_o / out_ready_i row_index, col_a..col_d, flags
//
// each input transfer yields four row transfers, rows 0 to 3 in order
// the shared normalize unit runs a 31-step square root and FRAC_BITS+1 divide steps,
//   at most twice per item
// a zero difference vector skips straight to the identity rows
// the input stage and a two-entry queue keep taking transfers while the
//   sequencer works; a stalled output row holds the sequencer only
// reset clears all control state; no clearing pass is needed

module look_at_view_matrix_top import lavm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] pos_x_i,
  input  logic [COORD_W-1:0] pos_y_i,
  input  logic [COORD_W-1:0] pos_z_i,
  input  logic [COORD_W-1:0] target_x_i,
  input  logic [COORD_W-1:0] target_y_i,
  input  logic [COORD_W-1:0] target_z_i,
  input  logic [COORD_W-1:0] up_x_i,
  input  logic [COORD_W-1:0] up_y_i,
  input  logic [COORD_W-1:0] up_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         row_index_o,
  output logic [COORD_W-1:0] col_a_o,
  output logic [COORD_W-1:0] col_b_o,
  output logic [COORD_W-1:0] col_c_o,
  output logic [COORD_W-1:0] col_d_o,
  output logic               degenerate_o,
  output logic               last_row_o
);

  localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

  logic push_valid;
  logic push_ready;
  item_t push_item;
  logic pop_valid;
  logic pop_ready;
  item_t pop_item;
  row_t out_row;

  // front: registers the transfer and forms the difference vector
  lavm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pos_i        ({pos_z_i, pos_y_i, pos_x_i}),
    .tgt_i        ({target_z_i, target_y_i, target_x_i}),
    .up_i         ({up_z_i, up_y_i, up_x_i}),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  // queue decouples the front from the sequencer
  lavm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // back: builds the matrix and drives the row output register
  lavm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row)
  );

  assign row_index_o  = out_row.row_index;
  assign col_a_o      = out_row.col_a;
  assign col_b_o      = out_row.col_b;
  assign col_c_o      = out_row.col_c;
  assign col_d_o      = out_row.col_d;
  assign degenerate_o = out_row.degenerate;
  assign last_row_o   = out_row.last_row;

  // last row flag marks exactly the fourth row
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_row_o == (row_index_o == ROW_LAST)))
    else $error("last_row flag does not match row index");

  // fourth row is always 0, 0, 0, one
  a_fourth_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_row_o) |->
      (col_a_o == '0 && col_b_o == '0 && col_c_o == '0 && col_d_o == ONE))
    else $error("fourth row is not 0 0 0 1");

  // degenerate first row is the identity row
  a_deg_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o && row_index_o == ROW_RIGHT) |->
      (col_a_o == ONE && col_b_o == '0 && col_c_o == '0 && col_d_o == '0))
    else $error("degenerate row 0 is not an identity row");

  // a row that follows a taken non-final row carries the next index
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_row_o) ##1 out_valid_o |->
      (row_index_o == $past(row_index_o) + 2'd1))
    else $error("rows out of order");

endmodule

// ===== rtl/core/lavm_front.sv =====
// input stage: takes a transfer, forms position minus target and flags a zero difference
`timescale 1ns / 1ps

module lavm_front import lavm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0][COORD_W-1:0] pos_i,
  input  logic [2:0][COORD_W-1:0] tgt_i,
  input  logic [2:0][COORD_W-1:0] up_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output item_t                   item_o
);

  logic                    hold_q;
  logic [2:0][COORD_W-1:0] pos_q;
  logic [2:0][COORD_W-1:0] tgt_q;
  logic [2:0][COORD_W-1:0] up_q;
  logic                    load;

  assign in_ready_o   = !hold_q || push_ready_i;
  assign load         = in_valid_i && in_ready_o;
  assign push_valid_o = hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (load) begin
      hold_q <= 1'b1;
    end else if (push_ready_i) begin
      hold_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pos_q <= pos_i;
      tgt_q <= tgt_i;
      up_q  <= up_i;
    end
  end

  always_comb begin
    item_o.pos = pos_q;
    item_o.up  = up_q;
    for (int i = 0; i < 3; i++) begin
      item_o.dlt[i] = DIFF_W'($signed(pos_q[i])) - DIFF_W'($signed(tgt_q[i]));
    end
    item_o.dzero = (item_o.dlt == '0);
  end

endmodule

// ===== rtl/core/lavm_fifo.sv =====
// two-entry queue between the input stage and the matrix sequencer
`timescale 1ns / 1ps

module lavm_fifo import lavm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  logic [1:0] cnt_q;
  item_t      ent0_q;
  item_t      ent1_q;
  logic       push;
  logic       pop;
  logic [1:0] wr_at;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = ent0_q;
  assign wr_at        = cnt_q - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && (wr_at == 2'd0)) begin
      ent0_q <= push_item_i;
    end else if (pop) begin
      ent0_q <= ent1_q;
    end
    if (push && (wr_at == 2'd1)) begin
      ent1_q <= push_item_i;
    end
  end

endmodule

// ===== rtl/core/lavm_norm.sv =====
// iterative normalize unit: prescale, sum of squares, square root, three dividers
`timescale 1ns / 1ps

module lavm_norm import lavm_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int CW        = 50
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [2:0][CW-1:0]        c_i,
  output nrm_stat_t                 stat_o,
  output logic [2:0][FRAC_BITS+1:0] r_o
);

  localparam int SQW = 62;
  localparam int LW  = 31;
  localparam int NW  = 30 + FRAC_BITS + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int RW  = FRAC_BITS + 2;
  localparam int JW  = $clog2(QW + 1);

  typedef enum logic [2:0] {
    N_IDLE, N_MAX, N_SHIFT, N_SQ, N_SUM, N_SQRT, N_DINIT, N_DIV
  } nstate_e;

  nstate_e          state_q;
  logic             done_q;
  logic             ok_q;
  logic [CW-1:0]    a_q   [3];
  logic             neg_q [3];
  logic [CW-1:0]    m_q;
  logic [59:0]      sq_q  [3];
  logic [SQW-1:0]   n_q;
  logic [SQW-1:0]   r_q;
  logic [4:0]       k_q;
  logic [LW-1:0]    len_q;
  logic [LW-1:0]    rem_q [3];
  logic [QW-1:0]    nlo_q [3];
  logic [QW-1:0]    quo_q [3];
  logic [JW-1:0]    j_q;
  logic [RW-1:0]    res_q [3];

  logic [SQW-1:0]   bit_w;
  logic [SQW-1:0]   rb;
  logic [CW-1:0]    mx;
  logic [LW:0]      trial [3];
  logic             qbit  [3];
  logic [QW-1:0]    qn    [3];
  logic [NW-1:0]    num   [3];

  always_comb begin
    bit_w = SQW'(1) << {k_q, 1'b0};
    rb    = r_q + bit_w;
    mx    = (a_q[0] > a_q[1]) ? a_q[0] : a_q[1];
    mx    = (a_q[2] > mx) ? a_q[2] : mx;
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_q[i], nlo_q[i][QW-1]};
      qbit[i]  = (trial[i] >= {1'b0, len_q});
      qn[i]    = {quo_q[i][QW-2:0], qbit[i]};
      num[i]   = (NW'(a_q[i][29:0]) << FRAC_BITS) + NW'(r_q[LW-1:0] >> 1);
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.ok   = ok_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_o[i] = res_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      // one-cycle pulse at the end of a zero vector or of the last divide step
      done_q <= ((state_q == N_SHIFT) && (m_q == '0)) ||
                ((state_q == N_DIV) && (j_q == JW'(1)));
      unique case (state_q)
        N_IDLE: begin
          if (start_i) begin
            state_q <= N_MAX;
          end
        end
        N_MAX:   state_q <= N_SHIFT;
        N_SHIFT: begin
          if (m_q == '0) begin
            ok_q    <= 1'b0;
            state_q <= N_IDLE;
          end else if (m_q[29] && (m_q[CW-1:30] == '0)) begin
            state_q <= N_SQ;
          end
        end
        N_SQ:    state_q <= N_SUM;
        N_SUM:   state_q <= N_SQRT;
        N_SQRT: begin
          if (k_q == 5'd0) begin
            state_q <= N_DINIT;
          end
        end
        N_DINIT: state_q <= N_DIV;
        N_DIV: begin
          if (j_q == JW'(1)) begin
            ok_q    <= 1'b1;
            state_q <= N_IDLE;
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      N_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          a_q[i]   <= c_i[i][CW-1] ? (CW'(0) - c_i[i]) : c_i[i];
          neg_q[i] <= c_i[i][CW-1];
        end
      end
      N_MAX: m_q <= mx;
      N_SHIFT: begin
        // coarse steps of four, then single steps, into [2^29, 2^30)
        priority if (m_q[CW-1:34] != '0) begin
          m_q <= m_q >> 4;
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 4;
        end else if (m_q[CW-1:30] != '0) begin
          m_q <= m_q >> 1;
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
        end else if (m_q != '0 && m_q[29:25] == '0) begin
          m_q <= m_q << 4;
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 4;
        end else if (m_q != '0 && !m_q[29]) begin
          m_q <= m_q << 1;
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
        end else begin
          m_q <= m_q;
        end
      end
      N_SQ: begin
        for (int i = 0; i < 3; i++) begin
          sq_q[i] <= 60'(a_q[i][29:0]) * 60'(a_q[i][29:0]);
        end
      end
      N_SUM: begin
        n_q <= SQW'(sq_q[0]) + SQW'(sq_q[1]) + SQW'(sq_q[2]);
        r_q <= '0;
        k_q <= 5'd30;
      end
      N_SQRT: begin
        if (n_q >= rb) begin
          n_q <= n_q - rb;
          r_q <= (r_q >> 1) + bit_w;
        end else begin
          r_q <= r_q >> 1;
        end
        k_q <= k_q - 5'd1;
      end
      N_DINIT: begin
        len_q <= r_q[LW-1:0];
        j_q   <= JW'(QW);
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= LW'(num[i] >> QW);
          nlo_q[i] <= num[i][QW-1:0];
          quo_q[i] <= '0;
        end
      end
      N_DIV: begin
        j_q <= j_q - JW'(1);
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= qbit[i] ? LW'(trial[i] - {1'b0, len_q}) : trial[i][LW-1:0];
          nlo_q[i] <= nlo_q[i] << 1;
          quo_q[i] <= qn[i];
          if (j_q == JW'(1)) begin
            res_q[i] <= neg_q[i] ? (RW'(0) - RW'(qn[i])) : RW'(qn[i]);
          end
        end
      end
      default: m_q <= m_q;
    endcase
  end

endmodule

// ===== rtl/core/lavm_back.sv =====
// matrix sequencer: two normalizations, cross products, dot products, row output register
`timescale 1ns / 1ps

module lavm_back import lavm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  pop_valid_i,
  output logic  pop_ready_o,
  input  item_t pop_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output row_t  out_row_o
);

  localparam int CW  = FRAC_BITS + 34;
  localparam int DW  = FRAC_BITS + 2;
  localparam int UW  = FRAC_BITS + 3;
  localparam int PW  = COORD_W + UW;
  localparam int DTW = PW + 2;
  localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;
  localparam logic signed [DTW-1:0] SMAX = (DTW'(1) << (COORD_W - 1)) - DTW'(1);
  localparam logic signed [DTW-1:0] SMIN = DTW'(0) - (DTW'(1) << (COORD_W - 1));

  typedef enum logic [3:0] {
    B_IDLE, B_N1, B_CRM, B_CRS, B_N2, B_UVM, B_UVS, B_DM, B_DS, B_DR, B_EMIT
  } bstate_e;

  function automatic logic signed [DTW-1:0] rnd_shift(input logic signed [DTW-1:0] v);
    logic [DTW-1:0] mag;
    logic [DTW-1:0] t;
    mag = v[DTW-1] ? (DTW'(0) - v) : v;
    t   = (mag + (DTW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[DTW-1] ? $signed(DTW'(0) - t) : $signed(t);
  endfunction

  function automatic logic [COORD_W-1:0] sat32(input logic signed [DTW-1:0] v);
    logic [COORD_W-1:0] res;
    priority if (v > SMAX) res = SMAX[COORD_W-1:0];
    else if (v < SMIN)     res = SMIN[COORD_W-1:0];
    else                   res = v[COORD_W-1:0];
    return res;
  endfunction

  bstate_e                    state_q;
  logic                       out_valid_q;
  logic [1:0]                 row_q;
  logic                       deg_q;
  row_t                       out_row_q;

  logic signed [COORD_W-1:0]  pos_q [3];
  logic signed [COORD_W-1:0]  up_q  [3];
  logic signed [DW-1:0]       dir_q [3];
  logic signed [DW-1:0]       rt_q  [3];
  logic signed [UW-1:0]       uv_q  [3];
  logic signed [PW-1:0]       prod_q [6];
  logic signed [DTW-1:0]      dot_q;
  logic [COORD_W-1:0]         trn_q;

  logic signed [COORD_W-1:0]  op_a  [6];
  logic signed [UW-1:0]       op_b  [6];
  logic signed [PW-1:0]       mul_d [6];
  logic signed [UW-1:0]       ax    [3];
  logic [2:0][CW-1:0]         nrm_c;
  logic                       nrm_start;
  nrm_stat_t                  nrm_stat;
  logic [2:0][FRAC_BITS+1:0]  nrm_r;
  logic                       out_free;
  logic                       take;
  row_t                       emit_row;

  assign pop_ready_o = (state_q == B_IDLE);
  assign take        = pop_valid_i && pop_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign nrm_start   = (take && !pop_item_i.dzero) || (state_q == B_CRS);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (state_q == B_IDLE) begin
        nrm_c[i] = CW'($signed(pop_item_i.dlt[i]));
      end else begin
        nrm_c[i] = CW'(prod_q[2*i] - prod_q[2*i+1]);
      end
    end
  end

  lavm_norm #(
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nrm_start),
    .c_i     (nrm_c),
    .stat_o  (nrm_stat),
    .r_o     (nrm_r)
  );

  // axis of the current row
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (row_q)
        ROW_RIGHT: ax[i] = UW'(rt_q[i]);
        ROW_UP:    ax[i] = uv_q[i];
        ROW_DIR:   ax[i] = UW'(dir_q[i]);
        default:   ax[i] = '0;
      endcase
    end
  end

  // shared multiplier bank operands
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      op_a[k] = '0;
      op_b[k] = '0;
    end
    case (state_q)
      B_CRM: begin
        op_a[0] = up_q[1]; op_b[0] = UW'(dir_q[2]);
        op_a[1] = up_q[2]; op_b[1] = UW'(dir_q[1]);
        op_a[2] = up_q[2]; op_b[2] = UW'(dir_q[0]);
        op_a[3] = up_q[0]; op_b[3] = UW'(dir_q[2]);
        op_a[4] = up_q[0]; op_b[4] = UW'(dir_q[1]);
        op_a[5] = up_q[1]; op_b[5] = UW'(dir_q[0]);
      end
      B_UVM: begin
        op_a[0] = COORD_W'(dir_q[1]); op_b[0] = UW'(rt_q[2]);
        op_a[1] = COORD_W'(dir_q[2]); op_b[1] = UW'(rt_q[1]);
        op_a[2] = COORD_W'(dir_q[2]); op_b[2] = UW'(rt_q[0]);
        op_a[3] = COORD_W'(dir_q[0]); op_b[3] = UW'(rt_q[2]);
        op_a[4] = COORD_W'(dir_q[0]); op_b[4] = UW'(rt_q[1]);
        op_a[5] = COORD_W'(dir_q[1]); op_b[5] = UW'(rt_q[0]);
      end
      B_DM: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = pos_q[i];
          op_b[i] = ax[i];
        end
      end
      default: op_a[0] = '0;
    endcase
    for (int k = 0; k < 6; k++) begin
      mul_d[k] = op_a[k] * op_b[k];
    end
  end

  always_comb begin
    emit_row.row_index  = row_q;
    emit_row.degenerate = deg_q;
    emit_row.last_row   = (row_q == ROW_LAST);
    if (deg_q) begin
      emit_row.col_a = (row_q == ROW_RIGHT) ? ONE : '0;
      emit_row.col_b = (row_q == ROW_UP)    ? ONE : '0;
      emit_row.col_c = (row_q == ROW_DIR)   ? ONE : '0;
      emit_row.col_d = (row_q == ROW_LAST)  ? ONE : '0;
    end else if (row_q == ROW_LAST) begin
      emit_row.col_a = '0;
      emit_row.col_b = '0;
      emit_row.col_c = '0;
      emit_row.col_d = ONE;
    end else begin
      emit_row.col_a = COORD_W'(ax[0]);
      emit_row.col_b = COORD_W'(ax[1]);
      emit_row.col_c = COORD_W'(ax[2]);
      emit_row.col_d = trn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      row_q       <= ROW_RIGHT;
      deg_q       <= 1'b0;
    end else begin
      if (out_ready_i && !(state_q == B_EMIT && out_free)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (take) begin
            row_q   <= ROW_RIGHT;
            deg_q   <= pop_item_i.dzero;
            state_q <= pop_item_i.dzero ? B_EMIT : B_N1;
          end
        end
        B_N1: begin
          if (nrm_stat.done) begin
            deg_q   <= !nrm_stat.ok;
            state_q <= nrm_stat.ok ? B_CRM : B_EMIT;
          end
        end
        B_CRM: state_q <= B_CRS;
        B_CRS: state_q <= B_N2;
        B_N2: begin
          if (nrm_stat.done) begin
            deg_q   <= !nrm_stat.ok;
            state_q <= nrm_stat.ok ? B_UVM : B_EMIT;
          end
        end
        B_UVM: state_q <= B_UVS;
        B_UVS: state_q <= B_DM;
        B_DM:  state_q <= B_DS;
        B_DS:  state_q <= B_DR;
        B_DR:  state_q <= B_EMIT;
        B_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (row_q == ROW_LAST) begin
              state_q <= B_IDLE;
            end else begin
              row_q <= row_q + 2'd1;
              if (!deg_q && row_q != ROW_DIR) begin
                state_q <= B_DM;
              end
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      prod_q[k] <= mul_d[k];
    end
    if (take) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= $signed(pop_item_i.pos[i]);
        up_q[i]  <= $signed(pop_item_i.up[i]);
      end
    end
    if (nrm_stat.done && state_q == B_N1) begin
      for (int i = 0; i < 3; i++) dir_q[i] <= $signed(nrm_r[i]);
    end
    if (nrm_stat.done && state_q == B_N2) begin
      for (int i = 0; i < 3; i++) rt_q[i] <= $signed(nrm_r[i]);
    end
    if (state_q == B_UVS) begin
      for (int i = 0; i < 3; i++) begin
        uv_q[i] <= UW'(rnd_shift(DTW'(prod_q[2*i]) - DTW'(prod_q[2*i+1])));
      end
    end
    if (state_q == B_DS) begin
      dot_q <= DTW'(prod_q[0]) + DTW'(prod_q[1]) + DTW'(prod_q[2]);
    end
    if (state_q == B_DR) begin
      trn_q <= sat32(DTW'(0) - rnd_shift(dot_q));
    end
    if (state_q == B_EMIT && out_free) begin
      out_row_q <= emit_row;
    end
  end

endmodule

// ===== dv/look_at_view_matrix_checker.sv =====
// scoreboard for the look-at view matrix block: predicts rows and compares transfers
`timescale 1ns / 1ps

module look_at_view_matrix_checker import lavm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [COORD_W-1:0] pos_x_i,
  input  logic [COORD_W-1:0] pos_y_i,
  input  logic [COORD_W-1:0] pos_z_i,
  input  logic [COORD_W-1:0] target_x_i,
  input  logic [COORD_W-1:0] target_y_i,
  input  logic [COORD_W-1:0] target_z_i,
  input  logic [COORD_W-1:0] up_x_i,
  input  logic [COORD_W-1:0] up_y_i,
  input  logic [COORD_W-1:0] up_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         row_index_i,
  input  logic [COORD_W-1:0] col_a_i,
  input  logic [COORD_W-1:0] col_b_i,
  input  logic [COORD_W-1:0] col_c_i,
  input  logic [COORD_W-1:0] col_d_i,
  input  logic               degenerate_i,
  input  logic               last_row_i,
  output int                 errors_o,
  output int                 pending_o
);

  localparam int FB = 16;
  localparam longint ONE_FX = longint'(1) << FB;

  typedef longint vec3_t [3];

  row_t rows_q [$];
  int   errors = 0;

  assign errors_o  = errors;
  assign pending_o = rows_q.size();

  function automatic longint unsigned abs64(input longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // round half away from zero, dropping FB fraction bits
  function automatic longint drop_frac(input longint v);
    longint unsigned a;
    a = (abs64(v) + (longint'(1) << (FB - 1))) >> FB;
    return (v < 0) ? -longint'(a) : longint'(a);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // unit vector in fixed point; returns 0 for a zero vector
  function automatic bit unit_vec(input vec3_t c, output vec3_t r);
    longint unsigned a [3];
    longint unsigned m, sum, len, q;
    int bl;
    m = 0;
    sum = 0;
    bl = 0;
    r = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      a[i] = abs64(c[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) return 1'b0;
    while ((m >> bl) != 0) bl++;
    for (int i = 0; i < 3; i++) begin
      if (bl > 30) a[i] = a[i] >> (bl - 30);
      else a[i] = a[i] << (30 - bl);
      sum += a[i] * a[i];
    end
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << FB) + (len >> 1)) / len;
      r[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic row_t make_row(input logic [1:0] k, input longint a, input longint b,
                                    input longint c, input longint d, input bit deg);
    row_t rw;
    rw.row_index  = k;
    rw.col_a      = clamp32(a);
    rw.col_b      = clamp32(b);
    rw.col_c      = clamp32(c);
    rw.col_d      = clamp32(d);
    rw.degenerate = deg;
    rw.last_row   = (k == ROW_LAST);
    return rw;
  endfunction

  task automatic predict_matrix();
    vec3_t p, u, dl, dir, cr, rt, uv;
    bit ok;
    longint dot;
    p  = '{longint'($signed(pos_x_i)), longint'($signed(pos_y_i)), longint'($signed(pos_z_i))};
    u  = '{longint'($signed(up_x_i)), longint'($signed(up_y_i)), longint'($signed(up_z_i))};
    dl = '{p[0] - longint'($signed(target_x_i)), p[1] - longint'($signed(target_y_i)),
           p[2] - longint'($signed(target_z_i))};
    ok = unit_vec(dl, dir);
    if (ok) begin
      cr[0] = u[1] * dir[2] - u[2] * dir[1];
      cr[1] = u[2] * dir[0] - u[0] * dir[2];
      cr[2] = u[0] * dir[1] - u[1] * dir[0];
      ok = unit_vec(cr, rt);
    end
    if (!ok) begin
      rows_q.push_back(make_row(ROW_RIGHT, ONE_FX, 0, 0, 0, 1'b1));
      rows_q.push_back(make_row(ROW_UP, 0, ONE_FX, 0, 0, 1'b1));
      rows_q.push_back(make_row(ROW_DIR, 0, 0, ONE_FX, 0, 1'b1));
      rows_q.push_back(make_row(ROW_LAST, 0, 0, 0, ONE_FX, 1'b1));
    end else begin
      uv[0] = drop_frac(dir[1] * rt[2] - dir[2] * rt[1]);
      uv[1] = drop_frac(dir[2] * rt[0] - dir[0] * rt[2]);
      uv[2] = drop_frac(dir[0] * rt[1] - dir[1] * rt[0]);
      dot = rt[0] * p[0] + rt[1] * p[1] + rt[2] * p[2];
      rows_q.push_back(make_row(ROW_RIGHT, rt[0], rt[1], rt[2], -drop_frac(dot), 1'b0));
      dot = uv[0] * p[0] + uv[1] * p[1] + uv[2] * p[2];
      rows_q.push_back(make_row(ROW_UP, uv[0], uv[1], uv[2], -drop_frac(dot), 1'b0));
      dot = dir[0] * p[0] + dir[1] * p[1] + dir[2] * p[2];
      rows_q.push_back(make_row(ROW_DIR, dir[0], dir[1], dir[2], -drop_frac(dot), 1'b0));
      rows_q.push_back(make_row(ROW_LAST, 0, 0, 0, ONE_FX, 1'b0));
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    row_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) predict_matrix();
      if (out_valid_i && out_ready_i) begin
        if (rows_q.size() == 0) begin
          report("unexpected row", {30'd0, row_index_i}, 32'd0);
        end else begin
          e = rows_q.pop_front();
          if (row_index_i != e.row_index)
            report("row_index", 32'(row_index_i), 32'(e.row_index));
          if (col_a_i != e.col_a) report("col_a", col_a_i, e.col_a);
          if (col_b_i != e.col_b) report("col_b", col_b_i, e.col_b);
          if (col_c_i != e.col_c) report("col_c", col_c_i, e.col_c);
          if (col_d_i != e.col_d) report("col_d", col_d_i, e.col_d);
          if (degenerate_i != e.degenerate)
            report("degenerate", 32'(degenerate_i), 32'(e.degenerate));
          if (last_row_i != e.last_row)
            report("last_row", 32'(last_row_i), 32'(e.last_row));
        end
      end
    end
  end

endmodule

// ===== dv/look_at_view_matrix_top_test.sv =====
// testbench top for the look-at view matrix block: stimulus, idling and verdict
`timescale 1ns / 1ps

module look_at_view_matrix_top_test;
  import lavm_pkg::*;

  localparam int RANDOM_ITEMS = 300;
  localparam int STALL_LIMIT  = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [COORD_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [COORD_W-1:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic [COORD_W-1:0] up_x_i = '0, up_y_i = '0, up_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         row_index_o;
  logic [COORD_W-1:0] col_a_o, col_b_o, col_c_o, col_d_o;
  logic               degenerate_o, last_row_o;

  int errors;
  int pending;
  int tx_idle_pct = 21;  // chance in a hundred that the sender pauses after a transfer
  int rx_idle_pct = 76;  // chance in a hundred that the receiver holds ready low
  int quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  look_at_view_matrix_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .pos_x_i, .pos_y_i, .pos_z_i, .target_x_i, .target_y_i, .target_z_i,
    .up_x_i, .up_y_i, .up_z_i,
    .out_valid_o, .out_ready_i, .row_index_o, .col_a_o, .col_b_o, .col_c_o, .col_d_o,
    .degenerate_o, .last_row_o
  );

  look_at_view_matrix_checker scoreboard (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .pos_x_i, .pos_y_i, .pos_z_i, .target_x_i, .target_y_i, .target_z_i,
    .up_x_i, .up_y_i, .up_z_i,
    .out_valid_i(out_valid_o), .out_ready_i, .row_index_i(row_index_o),
    .col_a_i(col_a_o), .col_b_i(col_b_o), .col_c_i(col_c_o), .col_d_i(col_d_o),
    .degenerate_i(degenerate_o), .last_row_i(last_row_o),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver: ready is redrawn every cycle at the current idle rate
  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL look_at_view_matrix_top");
      $finish;
    end
  end

  // one input transfer, driven at the current edge; valid stays high into the
  // next item unless a gap is drawn
  task automatic send_matrix(input logic [31:0] px, py, pz, tx, ty, tz, ux, uy, uz);
    int gap;
    in_valid_i <= 1'b1;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    target_x_i <= tx; target_y_i <= ty; target_z_i <= tz;
    up_x_i <= ux; up_y_i <= uy; up_z_i <= uz;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(12, 1);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // coordinate draw: mostly moderate magnitudes, some full range and edge values
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom();
      2:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      3:       return {{16{$urandom_range(1) == 1}}, 16'($urandom())};
      default: return 32'($signed(24'($urandom())));
    endcase
  endfunction

  initial begin
    logic [31:0] px, py, pz, tx, ty, tz, ux, uy, uz;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: ordinary view, camera on target, up along view, extremes, tiny offsets
    send_matrix(32'h0000_0000, 32'h0000_0000, 32'h0005_0000, 0, 0, 0,
                0, 32'h0001_0000, 0);
    send_matrix(32'h0003_0000, 32'hfffe_0000, 32'h0007_8000, 32'h0003_0000,
                32'hfffe_0000, 32'h0007_8000, 0, 32'h0001_0000, 0);
    send_matrix(0, 32'h0004_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0);
    send_matrix(32'h0002_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    send_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0,
                32'hffff_ffff, 0, 32'h0000_0001);
    send_matrix(1, 0, 0, 0, 0, 0, 0, 0, 1);
    send_matrix(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0);
    send_matrix(32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_matrix(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_matrix(32'h0000_8000, 32'hffff_8000, 32'h0001_0000, 32'hffff_0000,
                32'h0000_8000, 0, 32'h0000_0001, 32'h0000_0001, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // swap idle rates at one third, stop idling at two thirds
      if (n == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 76;
        rx_idle_pct = 21;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // hold-off: let every expected row drain before carrying on
      if (n == RANDOM_ITEMS / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      px = pick_coord(); py = pick_coord(); pz = pick_coord();
      ux = pick_coord(); uy = pick_coord(); uz = pick_coord();
      case ($urandom_range(19))
        0: begin  // camera on target
          tx = px; ty = py; tz = pz;
        end
        1: begin  // up hint parallel to the view direction
          tx = 0; ty = 0; tz = 0;
          ux = px; uy = py; uz = pz;
        end
        2: begin  // zero up hint
          tx = pick_coord(); ty = pick_coord(); tz = pick_coord();
          ux = 0; uy = 0; uz = 0;
        end
        default: begin
          tx = pick_coord(); ty = pick_coord(); tz = pick_coord();
        end
      endcase
      send_matrix(px, py, pz, tx, ty, tz, ux, uy, uz);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS look_at_view_matrix_top");
    end else begin
      $display("FAIL look_at_view_matrix_top");
    end
    $finish;
  end

endmodule
